// ===== hw/rtl/seven_channel_easing_tween_engine_unit_macros.svh =====
// Assertion macros for the tween engine checker.
// Depends on signals named clock and reset in the module that uses them.
`ifndef SEVEN_CHANNEL_EASING_TWEEN_ENGINE_UNIT_MACROS_SVH
`define SEVEN_CHANNEL_EASING_TWEEN_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TWEEN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TWEEN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tween_pkg.sv =====
// Shared constants, types and curve microcode for the tween engine.
// Used by every RTL module of the block except tween_ram; depends on nothing.
package tween_pkg;

   localparam int CHANNELS     = 7;
   localparam int OUT_CHANNELS = 7;
   localparam int CHAN_LIMIT   = (CHANNELS < OUT_CHANNELS) ? CHANNELS : OUT_CHANNELS;
   localparam int CHAN_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int VALUE_W    = 32;
   localparam int DUR_W      = 16;
   localparam int STEP_W     = 4;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = OUT_CHANNELS * VALUE_W;
   localparam int RSP_USER_W = 1;

   localparam logic [2:0] MODE_LOAD = 3'd0;
   localparam logic [2:0] MODE_TO   = 3'd1;
   localparam logic [2:0] MODE_BY   = 3'd2;
   localparam logic [2:0] MODE_SPAN = 3'd3;
   localparam logic [2:0] MODE_TICK = 3'd4;

   localparam logic [2:0] CURVE_IDLE     = 3'd0;
   localparam logic [2:0] CURVE_LINEAR   = 3'd1;
   localparam logic [2:0] CURVE_SMOOTH   = 3'd2;
   localparam logic [2:0] CURVE_PULSE    = 3'd3;
   localparam logic [2:0] CURVE_EASE_OUT = 3'd4;
   localparam logic [2:0] CURVE_EASE_IN  = 3'd5;

   typedef struct packed {
      logic [2:0]         curve;
      logic [VALUE_W-1:0] cur;
      logic [VALUE_W-1:0] start;
      logic [VALUE_W-1:0] target;
   } chan_entry_type;

   typedef struct packed {
      logic [2:0]         curve;
      logic [VALUE_W-1:0] start;
      logic [VALUE_W-1:0] target;
      logic [DUR_W-1:0]   span;
      logic [DUR_W-1:0]   elapsed;
   } eval_req_type;

   typedef enum logic [1:0] {
      UOP_MUL = 2'd0,
      UOP_DIV = 2'd1,
      UOP_END = 2'd2
   } uop_kind_type;

   typedef enum logic [3:0] {
      SRC_ONE   = 4'd0,
      SRC_E     = 4'd1,
      SRC_D     = 4'd2,
      SRC_H     = 4'd3,
      SRC_DIST  = 4'd4,
      SRC_DIFF  = 4'd5,
      SRC_ACC   = 4'd6,
      SRC_AUX   = 4'd7,
      SRC_NEG2  = 4'd8,
      SRC_THREE = 4'd9
   } src_type;

   typedef enum logic [1:0] {
      DST_ACC = 2'd0,
      DST_AUX = 2'd1,
      DST_DEN = 2'd2
   } dst_type;

   typedef enum logic [1:0] {
      RES_S_ACC     = 2'd0,
      RES_T_ACC     = 2'd1,
      RES_S_AUX_ACC = 2'd2
   } res_type;

   typedef struct packed {
      uop_kind_type kind;
      src_type      x;
      src_type      y;
      dst_type      dst;
      res_type      res;
   } uop_type;

   function automatic uop_type mk_mul(src_type x, src_type y, dst_type dst);
      uop_type u;
      u = '{kind: UOP_MUL, x: x, y: y, dst: dst, res: RES_S_ACC};
      return u;
   endfunction

   function automatic uop_type mk_div();
      uop_type u;
      u = '{kind: UOP_DIV, x: SRC_ONE, y: SRC_ONE, dst: DST_ACC, res: RES_S_ACC};
      return u;
   endfunction

   function automatic uop_type mk_end(res_type res);
      uop_type u;
      u = '{kind: UOP_END, x: SRC_ONE, y: SRC_ONE, dst: DST_ACC, res: res};
      return u;
   endfunction

   // Curve programs: multiplies into acc/aux/den, divides acc by den, then combine.
   function automatic uop_type uop_of(logic [2:0] curve, logic [STEP_W-1:0] step);
      uop_type u;
      u = mk_end(RES_S_ACC);
      unique case (curve)
         CURVE_LINEAR: begin
            unique case (step)
               4'd0:    u = mk_mul(SRC_D, SRC_ONE, DST_DEN);
               4'd1:    u = mk_mul(SRC_E, SRC_DIFF, DST_ACC);
               4'd2:    u = mk_div();
               default: u = mk_end(RES_S_ACC);
            endcase
         end
         CURVE_SMOOTH: begin
            unique case (step)
               4'd0:    u = mk_mul(SRC_D, SRC_ONE, DST_DEN);
               4'd1:    u = mk_mul(SRC_DIFF, SRC_NEG2, DST_ACC);
               4'd2:    u = mk_mul(SRC_E, SRC_ACC, DST_ACC);
               4'd3:    u = mk_div();
               4'd4:    u = mk_mul(SRC_E, SRC_ACC, DST_ACC);
               4'd5:    u = mk_div();
               4'd6:    u = mk_mul(SRC_E, SRC_ACC, DST_ACC);
               4'd7:    u = mk_div();
               4'd8:    u = mk_mul(SRC_ACC, SRC_ONE, DST_AUX);
               4'd9:    u = mk_mul(SRC_DIFF, SRC_THREE, DST_ACC);
               4'd10:   u = mk_mul(SRC_E, SRC_ACC, DST_ACC);
               4'd11:   u = mk_div();
               4'd12:   u = mk_mul(SRC_E, SRC_ACC, DST_ACC);
               4'd13:   u = mk_div();
               default: u = mk_end(RES_S_AUX_ACC);
            endcase
         end
         CURVE_PULSE, CURVE_EASE_OUT: begin
            unique case (step)
               4'd0: begin
                  if (curve == CURVE_PULSE) u = mk_mul(SRC_H, SRC_H, DST_DEN);
                  else                      u = mk_mul(SRC_D, SRC_D, DST_DEN);
               end
               4'd1:    u = mk_mul(SRC_DIFF, SRC_DIST, DST_ACC);
               4'd2:    u = mk_mul(SRC_ACC, SRC_DIST, DST_ACC);
               4'd3:    u = mk_div();
               default: u = mk_end(RES_T_ACC);
            endcase
         end
         CURVE_EASE_IN: begin
            unique case (step)
               4'd0:    u = mk_mul(SRC_D, SRC_D, DST_DEN);
               4'd1:    u = mk_mul(SRC_DIFF, SRC_E, DST_ACC);
               4'd2:    u = mk_mul(SRC_ACC, SRC_E, DST_ACC);
               4'd3:    u = mk_div();
               default: u = mk_end(RES_S_ACC);
            endcase
         end
         default: u = mk_end(RES_S_ACC);
      endcase
      return u;
   endfunction

endpackage

// ===== hw/rtl/tween_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tween_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tween_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on tween_pkg for the value width.
module tween_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tween_pkg::VALUE_W-1:0] numer,
   input  logic [tween_pkg::VALUE_W-1:0] denom,
   output logic                          done,
   output logic [tween_pkg::VALUE_W-1:0] quot
);
   import tween_pkg::*;

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIN  = 3'b100
   } dstate_type;

   dstate_type         state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [VALUE_W-1:0] dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic               done_ff, done_in;
   logic [VALUE_W:0]   rem_sh;
   logic [VALUE_W:0]   trial;
   logic               fits;

   assign rem_sh = {rem_ff, quo_ff[VALUE_W-1]};
   assign trial  = rem_sh - {1'b0, dvs_ff};
   assign fits   = !trial[VALUE_W];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               if (denom == '0) begin
                  // divide by zero: +1 for a negative numerator, -1 otherwise
                  quot_in = numer[VALUE_W-1] ? VALUE_W'(1) : '1;
                  done_in = 1'b1;
               end else begin
                  quo_in   = numer[VALUE_W-1] ? -numer : numer;
                  dvs_in   = denom[VALUE_W-1] ? -denom : denom;
                  rem_in   = '0;
                  cnt_in   = '0;
                  neg_in   = numer[VALUE_W-1] ^ denom[VALUE_W-1];
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            rem_in = fits ? trial[VALUE_W-1:0] : rem_sh[VALUE_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], fits};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = D_FIN;
         end
         D_FIN: begin
            quot_in  = neg_ff ? -quo_ff : quo_ff;
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hw/rtl/tween_eval.sv =====
// Curve evaluator: runs one curve program on a shared multiplier and divider.
// Depends on tween_pkg (types, microcode) and tween_div.
module tween_eval (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  tween_pkg::eval_req_type       req,
   output logic                          done,
   output logic [tween_pkg::VALUE_W-1:0] result
);
   import tween_pkg::*;

   typedef enum logic [2:0] {
      E_IDLE = 3'b001,
      E_RUN  = 3'b010,
      E_DIVW = 3'b100
   } estate_type;

   estate_type          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [2:0]          curve_ff, curve_in;
   logic [VALUE_W-1:0]  s_ff, s_in;
   logic [VALUE_W-1:0]  t_ff, t_in;
   logic [VALUE_W-1:0]  diff_ff, diff_in;
   logic [DUR_W-1:0]    e_ff, e_in;
   logic [DUR_W-1:0]    d_ff, d_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [VALUE_W-1:0]  aux_ff, aux_in;
   logic [VALUE_W-1:0]  den_ff, den_in;
   logic [VALUE_W-1:0]  result_ff, result_in;
   logic                done_ff, done_in;

   uop_type             uop;
   logic [VALUE_W-1:0]  e_ext, d_ext, h_ext, e_off;
   logic [VALUE_W-1:0]  mul_x, mul_y, prod;
   logic [VALUE_W-1:0]  final_val;
   logic                div_start, div_done;
   logic [VALUE_W-1:0]  div_quot;

   assign uop   = uop_of(curve_ff, step_ff);
   assign e_ext = {{(VALUE_W-DUR_W){1'b0}}, e_ff};
   assign d_ext = {{(VALUE_W-DUR_W){1'b0}}, d_ff};
   assign h_ext = {{(VALUE_W-DUR_W+1){1'b0}}, d_ff[DUR_W-1:1]};
   assign e_off = e_ext - ((curve_ff == CURVE_PULSE) ? h_ext : d_ext);

   always_comb begin
      unique case (uop.x)
         SRC_ONE:   mul_x = VALUE_W'(1);
         SRC_E:     mul_x = e_ext;
         SRC_D:     mul_x = d_ext;
         SRC_H:     mul_x = h_ext;
         SRC_DIST:  mul_x = e_off;
         SRC_DIFF:  mul_x = diff_ff;
         SRC_ACC:   mul_x = acc_ff;
         SRC_AUX:   mul_x = aux_ff;
         SRC_NEG2:  mul_x = -VALUE_W'(2);
         SRC_THREE: mul_x = VALUE_W'(3);
         default:   mul_x = '0;
      endcase
      unique case (uop.y)
         SRC_ONE:   mul_y = VALUE_W'(1);
         SRC_E:     mul_y = e_ext;
         SRC_D:     mul_y = d_ext;
         SRC_H:     mul_y = h_ext;
         SRC_DIST:  mul_y = e_off;
         SRC_DIFF:  mul_y = diff_ff;
         SRC_ACC:   mul_y = acc_ff;
         SRC_AUX:   mul_y = aux_ff;
         SRC_NEG2:  mul_y = -VALUE_W'(2);
         SRC_THREE: mul_y = VALUE_W'(3);
         default:   mul_y = '0;
      endcase
   end

   // low word only: all curve math wraps at 32 bits
   assign prod = mul_x * mul_y;

   always_comb begin
      unique case (uop.res)
         RES_S_ACC:     final_val = s_ff + acc_ff;
         RES_T_ACC:     final_val = t_ff - acc_ff;
         RES_S_AUX_ACC: final_val = s_ff + aux_ff + acc_ff;
         default:       final_val = s_ff + acc_ff;
      endcase
   end

   assign div_start = (state_ff == E_RUN) && (uop.kind == UOP_DIV);

   tween_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (acc_ff),
      .denom (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      curve_in  = curve_ff;
      s_in      = s_ff;
      t_in      = t_ff;
      diff_in   = diff_ff;
      e_in      = e_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;
      aux_in    = aux_ff;
      den_in    = den_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               curve_in = req.curve;
               s_in     = req.start;
               t_in     = req.target;
               diff_in  = req.target - req.start;
               e_in     = req.elapsed;
               d_in     = req.span;
               step_in  = '0;
               state_in = E_RUN;
            end
         end
         E_RUN: begin
            unique case (uop.kind)
               UOP_MUL: begin
                  unique case (uop.dst)
                     DST_ACC: acc_in = prod;
                     DST_AUX: aux_in = prod;
                     DST_DEN: den_in = prod;
                     default: acc_in = prod;
                  endcase
                  step_in = step_ff + STEP_W'(1);
               end
               UOP_DIV: state_in = E_DIVW;
               default: begin
                  result_in = final_val;
                  done_in   = 1'b1;
                  state_in  = E_IDLE;
               end
            endcase
         end
         E_DIVW: begin
            if (div_done) begin
               acc_in   = div_quot;
               step_in  = step_ff + STEP_W'(1);
               state_in = E_RUN;
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      curve_ff  <= curve_in;
      s_ff      <= s_in;
      t_ff      <= t_in;
      diff_ff   <= diff_in;
      e_ff      <= e_in;
      d_ff      <= d_in;
      acc_ff    <= acc_in;
      aux_ff    <= aux_in;
      den_ff    <= den_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== hw/rtl/seven_channel_easing_tween_engine_unit.sv =====
// Top level of the seven-channel easing tween engine.
// Depends on tween_pkg, tween_ram and tween_eval.
//
// Every item returns one result holding the finished flag and all seven channel values.
// Load and transition items pass through the channel RAM (read, latch, write back) before
// their result; set-duration, ignored items and ticks that do not advance go straight
// to the result. A tick that advances walks the channels one by one through the channel
// RAM (read, update, write back) and runs each moving channel's curve on one shared
// multiplier and a radix-2 divider; smoothstep takes five divisions. The next item is
// taken while the previous result still waits on the output register.
module seven_channel_easing_tween_engine_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // channel[2:0], curve[5:3], operand[37:6], zero[39:38]
   input  logic [tween_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[2:0]
   input  logic [tween_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // position_x[31:0], position_y, position_z, rotation_x, rotation_y,
   // rotation_z, scale_value[223:192]
   output logic [tween_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // finished[0]
   output logic [tween_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tween_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_LATCH  = 6'b000100,
      S_EVAL   = 6'b001000,
      S_WRITE  = 6'b010000,
      S_RESULT = 6'b100000
   } state_type;

   localparam logic [3:0]           ChanLimit4 = 4'(CHAN_LIMIT);
   localparam logic [CHAN_BITS-1:0] LastIdx    = CHAN_BITS'(CHANNELS - 1);

   state_type              state_ff, state_in;
   logic [2:0]             mode_ff, mode_in;
   logic [2:0]             curve_ff, curve_in;
   logic [VALUE_W-1:0]     operand_ff, operand_in;
   logic [CHAN_BITS-1:0]   idx_ff, idx_in;
   logic                   last_ff, last_in;
   logic                   rd_ok_ff, rd_ok_in;
   chan_entry_type         entry_ff, entry_in;
   logic [DUR_W-1:0]       span_ff, span_in;
   logic [DUR_W-1:0]       ticks_ff, ticks_in;
   logic [CHANNELS-1:0]    valid_ff;
   logic [VALUE_W-1:0]     view_ff [CHANNELS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_fin_ff, rsp_fin_in;

   logic [2:0]             req_mode, req_ch, req_curve;
   logic [VALUE_W-1:0]     req_op;
   logic                   ch_ok, tick_go, finished, accept, is_active;
   logic [DUR_W-1:0]       ticks_next;
   logic                   ram_wr_en, ram_rd_en;
   logic [$bits(chan_entry_type)-1:0] ram_rd_data;
   chan_entry_type         rd_entry;
   logic [RSP_DATA_W-1:0]  view_flat;
   logic                   eval_start, eval_done;
   logic [VALUE_W-1:0]     eval_result;
   eval_req_type           eval_req;

   assign req_mode  = req_tuser[2:0];
   assign req_ch    = req_tdata[2:0];
   assign req_curve = req_tdata[5:3];
   assign req_op    = req_tdata[37:6];

   assign accept     = req_tvalid && req_tready;
   assign ch_ok      = {1'b0, req_ch} < ChanLimit4;
   assign tick_go    = $signed({1'b0, ticks_ff}) < $signed({span_ff[DUR_W-1], span_ff});
   assign finished   = $signed({1'b0, ticks_ff}) >= $signed({span_ff[DUR_W-1], span_ff});
   assign ticks_next = ticks_ff + DUR_W'(1);

   // never-written entries read as the reset state
   assign rd_entry  = rd_ok_ff ? chan_entry_type'(ram_rd_data) : '0;
   assign is_active = (rd_entry.curve >= CURVE_LINEAR) && (rd_entry.curve <= CURVE_EASE_IN);
   assign eval_req  = '{curve: rd_entry.curve, start: rd_entry.start,
                        target: rd_entry.target, span: span_ff, elapsed: ticks_ff};

   for (genvar j = 0; j < OUT_CHANNELS; j++) begin : g_out
      if (j < CHANNELS) begin : g_live
         assign view_flat[j*VALUE_W +: VALUE_W] = view_ff[j];
      end else begin : g_none
         assign view_flat[j*VALUE_W +: VALUE_W] = '0;
      end
   end

   // One access per entry at a time: the next read is issued only after the write-back
   // cycle, so no read can see a stale entry.
   tween_ram #(
      .WIDTH ($bits(chan_entry_type)),
      .DEPTH (CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (entry_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   tween_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .start  (eval_start),
      .req    (eval_req),
      .done   (eval_done),
      .result (eval_result)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      curve_in     = curve_ff;
      operand_in   = operand_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rd_ok_in     = rd_ok_ff;
      entry_in     = entry_ff;
      span_in      = span_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_fin_in   = rsp_fin_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      eval_start   = 1'b0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               curve_in   = req_curve;
               operand_in = req_op;
               state_in   = S_RESULT;
               unique case (req_mode)
                  MODE_LOAD, MODE_TO, MODE_BY: begin
                     if (ch_ok) begin
                        idx_in   = CHAN_BITS'({1'b0, req_ch});
                        state_in = S_READ;
                     end
                  end
                  MODE_SPAN: begin
                     span_in  = req_op[DUR_W-1:0];
                     ticks_in = '0;
                  end
                  MODE_TICK: begin
                     if (tick_go) begin
                        ticks_in = ticks_next;
                        last_in  = (ticks_next == span_ff);
                        idx_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  default: state_in = S_RESULT;
               endcase
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            rd_ok_in  = valid_ff[idx_ff];
            state_in  = S_LATCH;
         end
         S_LATCH: begin
            entry_in = rd_entry;
            state_in = S_WRITE;
            unique case (mode_ff)
               MODE_LOAD: entry_in.cur = operand_ff;
               MODE_TO, MODE_BY: begin
                  entry_in.curve  = curve_ff;
                  entry_in.start  = rd_entry.cur;
                  entry_in.target = (mode_ff == MODE_TO) ? operand_ff
                                                         : rd_entry.cur + operand_ff;
               end
               default: begin
                  // tick: drop the curve to idle on the final step
                  entry_in.curve = last_ff ? CURVE_IDLE : rd_entry.curve;
                  if (is_active) begin
                     eval_start = 1'b1;
                     state_in   = S_EVAL;
                  end
               end
            endcase
         end
         S_EVAL: begin
            if (eval_done) begin
               entry_in.cur = eval_result;
               state_in     = S_WRITE;
            end
         end
         S_WRITE: begin
            ram_wr_en = 1'b1;
            if ((mode_ff == MODE_TICK) && (idx_ff != LastIdx)) begin
               idx_in   = idx_ff + CHAN_BITS'(1);
               state_in = S_READ;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = view_flat;
               rsp_fin_in   = finished;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         span_ff      <= '0;
         ticks_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) view_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         span_ff      <= span_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
            view_ff[idx_ff]  <= entry_ff.cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      curve_ff    <= curve_in;
      operand_ff  <= operand_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      rd_ok_ff    <= rd_ok_in;
      entry_ff    <= entry_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fin_ff  <= rsp_fin_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fin_ff;

endmodule

// ===== hw/rtl/tween_check.sv =====
// Port-level checker for the tween engine, bound to the top level.
// Depends on tween_pkg and the assertion macro header.
`include "seven_channel_easing_tween_engine_unit_macros.svh"

module tween_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [tween_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [tween_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tween_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [tween_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tween_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       in_xfer, out_xfer;
   logic       unused_ok;

   assign in_xfer   = req_tvalid && req_tready;
   assign out_xfer  = rsp_tvalid && rsp_tready;
   assign unused_ok = ^{req_tdata, req_tuser};

   // items taken minus results delivered
   always_comb begin
      pend_in = pend_ff;
      if (in_xfer && !out_xfer) pend_in = pend_ff + 2'd1;
      if (out_xfer && !in_xfer) pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else       pend_ff <= pend_in;
   end

   `TWEEN_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")
   `TWEEN_ASSERT_NOW(a_no_orphan, rsp_tvalid, pend_ff != 2'd0 || unused_ok != unused_ok, "result offered with no item pending")
   `TWEEN_ASSERT_NOW(a_depth, in_xfer, pend_ff < 2'd2, "item taken with two results outstanding")
   `TWEEN_ASSERT_NOW(a_one_each, out_xfer && !in_xfer, pend_ff != 2'd0, "more results than items")

endmodule

bind seven_channel_easing_tween_engine_unit tween_check u_tween_check (.*);
